// ===== rtl/core/plt_pkg.sv =====
// ---------------------------------------------------------------------------
// plt_pkg: shared types for the positional list table
// Command codes, per-cell control word and the request/response payloads.
// ---------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  // Command codes carried in the request
  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_READ      = 2'd2,
    CMD_OVERWRITE = 2'd3
  } cmd_e;

  // Action broadcast to every cell of the chain
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_WRITE  = 2'd3
  } cell_act_e;

  // Broadcast control: action, 0-based target index and new value
  typedef struct packed {
    cell_act_e    act;
    logic [7:0]   idx;
    logic signed [31:0] value;
  } cell_ctrl_t;

  // Request payload
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] new_value;
  } plt_req_t;

  // Response payload
  typedef struct packed {
    logic signed [31:0] read_value;
    logic               failed;
    logic [4:0]         element_count;
    logic               is_empty;
  } plt_rsp_t;

  localparam logic signed [31:0] ReadFailValue = -32'sd1;

endpackage

`default_nettype wire

// ===== rtl/core/plt_cell.sv =====
// ---------------------------------------------------------------------------
// plt_cell: one storage cell of the list chain
// Holds one entry; loads the new value, or takes the entry of its left or
// right neighbor, depending on the broadcast action and its own index.
// ---------------------------------------------------------------------------
`default_nettype none

module plt_cell import plt_pkg::*; #(
  parameter int CellIndex = 0
) (
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]      entry_o
);

  localparam logic [7:0] MyIdx = 8'(CellIndex);

  logic signed [31:0] entry_d, entry_q;

  // Next entry: shift in from a neighbor or load the new value
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.act)
      ACT_INSERT: begin
        if (MyIdx == ctrl_i.idx) begin
          entry_d = ctrl_i.value;
        end else if (MyIdx > ctrl_i.idx) begin
          entry_d = left_i;
        end
      end
      ACT_REMOVE: begin
        if (MyIdx >= ctrl_i.idx) begin
          entry_d = right_i;
        end
      end
      ACT_WRITE: begin
        if (MyIdx == ctrl_i.idx) begin
          entry_d = ctrl_i.value;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_table.sv =====
// ---------------------------------------------------------------------------
// positional_list_table: bounded ordered list addressed by 1-based position
// A chain of cells holds the entries; insert and remove shift all later
// cells at once, so every command is accepted without a busy state.
// ---------------------------------------------------------------------------
//
//  Channel   | Handshake              | Payload
//  ----------+------------------------+----------------------------
//  request   | start_i, busy_o        | req_i  (cmd, position, new_value)
//  response  | done_o (one-cycle)     | rsp_o  (read_value, failed,
//            |                        |         element_count, is_empty)
//
//  A command is taken at every edge with start_i high; busy_o stays low.
//  Its response appears in the following cycle for exactly one cycle with done_o.
//  One command per cycle: the cell chain shifts in the accept cycle.
//  Reset clears the element count; cell contents are undefined until written.
//  The receiver cannot stall; nothing is held back.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_table import plt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire plt_req_t req_i,
  output logic          done_o,
  output plt_rsp_t      rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam logic [8:0] CapVal = 9'(CAPACITY);

  logic [CntW-1:0]    count_d, count_q;
  logic               done_d, done_q;
  plt_rsp_t           rsp_d, rsp_q;
  cell_ctrl_t         ctrl;
  logic signed [31:0] entries [CAPACITY];
  logic [8:0]         cnt9, pos9;
  logic [7:0]         idx;
  logic               in_range, ins_ok;

  assign busy_o = 1'b0;

  // Position checks against the current count
  assign cnt9     = 9'(count_q);
  assign pos9     = {1'b0, req_i.position};
  assign idx      = req_i.position - 8'd1;
  assign in_range = (pos9 != 9'd0) && (pos9 <= cnt9);
  assign ins_ok   = (pos9 != 9'd0) && (pos9 <= cnt9 + 9'd1) && (cnt9 < CapVal);

  // Command decode: cell action, new count and response
  always_comb begin
    ctrl.act   = ACT_HOLD;
    ctrl.idx   = idx;
    ctrl.value = req_i.new_value;
    count_d    = count_q;
    rsp_d.read_value = '0;
    rsp_d.failed     = 1'b0;
    if (start_i) begin
      case (req_i.cmd)
        CMD_INSERT: begin
          if (ins_ok) begin
            ctrl.act = ACT_INSERT;
            count_d  = count_q + CntW'(1);
          end else begin
            rsp_d.failed = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (in_range) begin
            ctrl.act = ACT_REMOVE;
            count_d  = count_q - CntW'(1);
          end else begin
            rsp_d.failed = 1'b1;
          end
        end
        CMD_READ: begin
          if (in_range) begin
            rsp_d.read_value = entries[idx[IdxW-1:0]];
          end else begin
            rsp_d.failed     = 1'b1;
            rsp_d.read_value = ReadFailValue;
          end
        end
        CMD_OVERWRITE: begin
          if (in_range) begin
            ctrl.act = ACT_WRITE;
          end else begin
            rsp_d.failed = 1'b1;
          end
        end
        default: rsp_d.failed = 1'b1;
      endcase
    end
    rsp_d.element_count = 5'(count_d);
    rsp_d.is_empty      = (count_d == '0);
    done_d              = start_i;
  end

  // Cell chain; each cell sees both neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entries[g+1];
    end
    plt_cell #(
      .CellIndex(g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries[g])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
